>>> hdl/spr_pkg.sv
package spr_pkg;

  // default configuration of the stack
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // fixed field widths of the channel words
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned PUSH_W    = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned TOP_W     = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_DUP  = 3'd1,
    MODE_DROP = 3'd2,
    MODE_DIG  = 3'd3,
    MODE_DUG  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle command seen by every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_DOWN,
    CELL_SHIFT_UP,
    CELL_SWAP,
    CELL_LOAD_LANE,
    CELL_LANE_UP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     swap_lo;
    logic     swap_hi;
  } cell_ctrl_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PUSH_W-1:0] push_value;
    logic [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [TOP_W-1:0]   top_value;
    logic [COUNT_W-1:0] entry_count;
    status_e            status;
  } out_word_t;

endpackage

>>> hdl/spr_cell.sv
module spr_cell #(
  parameter int unsigned VALUE_WIDTH = spr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  spr_pkg::cell_ctrl_t    ctrl_i,
  input  logic [VALUE_WIDTH-1:0] prev_data_i,
  input  logic [VALUE_WIDTH-1:0] next_data_i,
  input  logic [VALUE_WIDTH-1:0] next_lane_i,
  output logic [VALUE_WIDTH-1:0] data_o,
  output logic [VALUE_WIDTH-1:0] lane_o
);

  logic [VALUE_WIDTH-1:0] data_q, data_d;
  logic [VALUE_WIDTH-1:0] lane_q, lane_d;

  always_comb begin
    data_d = data_q;
    lane_d = lane_q;
    case (ctrl_i.op)
      spr_pkg::CELL_SHIFT_DOWN: data_d = prev_data_i;
      spr_pkg::CELL_SHIFT_UP:   data_d = next_data_i;
      spr_pkg::CELL_SWAP: begin
        if (ctrl_i.swap_lo) begin
          data_d = next_data_i;
        end else if (ctrl_i.swap_hi) begin
          data_d = prev_data_i;
        end
      end
      spr_pkg::CELL_LOAD_LANE:  lane_d = data_q;
      spr_pkg::CELL_LANE_UP:    lane_d = next_lane_i;
      default: ;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    lane_q <= lane_d;
  end

  assign data_o = data_q;
  assign lane_o = lane_q;

endmodule

>>> hdl/stack_with_pick_roll_drop_unit.sv
// flow: errors and no-ops go from idle straight to S_DONE; push shifts the chain down once;
//   dup loads lanes, walks them up n cells, pushes; drop shifts up n; dig/dug swap pairs in turn
// throughput: one word in flight at a time, set by the neighbor-to-neighbor moves
//   of the cell chain; the next word is taken while a result waits at the output
// reset: asynchronous, active low; the stack comes up empty, cell contents are not cleared
module stack_with_pick_roll_drop_unit #(
  parameter int unsigned STACK_DEPTH = spr_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = spr_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spr_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spr_pkg::out_word_t out_data_o
);

  // cell index width and entry count width
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  // compare width: holds count, position and position plus two
  localparam int unsigned CMP_W = ((CNT_W > spr_pkg::POS_W) ? CNT_W : spr_pkg::POS_W) + 2;

  // sequencer states: each busy state issues one command to the whole chain per cycle
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,      // shift chain down, new value enters cell 0
    S_LOAD,      // dup: copy every cell into its lane register
    S_LANE,      // dup: walk the lane up one cell per cycle
    S_PUSH_LANE, // dup: shift chain down, lane of cell 0 enters cell 0
    S_SHIFT_UP,  // drop: shift chain up one entry per cycle
    S_SWAP_UP,   // dug: swap pair (ptr, ptr+1), ptr climbs toward depth n
    S_SWAP_DOWN, // dig: swap pair (ptr, ptr+1), ptr falls toward the top
    S_DONE       // load the result register
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       steps_q;
  logic [IDX_W-1:0]       ptr_q;
  logic [VALUE_WIDTH-1:0] val_q;
  spr_pkg::status_e       status_q;
  logic                   out_valid_q;
  spr_pkg::out_word_t     out_data_q;

  // cells hold the stack top-relative: cell 0 is the top entry
  logic [VALUE_WIDTH-1:0] cell_data [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] cell_lane [STACK_DEPTH];
  spr_pkg::cell_ctrl_t    cell_ctrl [STACK_DEPTH];
  spr_pkg::cell_op_e      cell_op;
  logic [VALUE_WIDTH-1:0] feed;

  // operand decode of the offered word
  logic [CMP_W-1:0]       c_ext, n_ext, depth_ext;
  logic [63:0]            push_wide;
  logic [VALUE_WIDTH-1:0] push_val;
  logic [63:0]            top_wide;
  logic [spr_pkg::TOP_W-1:0] top_now;
  logic                   accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign c_ext      = CMP_W'(count_q);
  assign n_ext      = CMP_W'(in_data_i.position);
  assign depth_ext  = CMP_W'(STACK_DEPTH);
  // pushed word masked or zero-extended to the stored width
  assign push_wide  = 64'(in_data_i.push_value);
  assign push_val   = push_wide[VALUE_WIDTH-1:0];
  // top entry seen through the 32-bit result field, zero when empty
  assign top_wide   = 64'(cell_data[0]);
  assign top_now    = (count_q != '0) ? top_wide[spr_pkg::TOP_W-1:0] : '0;

  // chain command for this cycle
  always_comb begin
    case (state_q)
      S_PUSH, S_PUSH_LANE:    cell_op = spr_pkg::CELL_SHIFT_DOWN;
      S_LOAD:                 cell_op = spr_pkg::CELL_LOAD_LANE;
      S_LANE:                 cell_op = spr_pkg::CELL_LANE_UP;
      S_SHIFT_UP:             cell_op = spr_pkg::CELL_SHIFT_UP;
      S_SWAP_UP, S_SWAP_DOWN: cell_op = spr_pkg::CELL_SWAP;
      default:                cell_op = spr_pkg::CELL_HOLD;
    endcase
  end

  // cell 0 takes the pushed value, or its own lane copy on dup
  assign feed = (state_q == S_PUSH_LANE) ? cell_lane[0] : val_q;

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    localparam logic [IDX_W:0] K = (IDX_W + 1)'(k);
    logic [VALUE_WIDTH-1:0] prev_data, next_data, next_lane;

    assign cell_ctrl[k].op      = cell_op;
    assign cell_ctrl[k].swap_lo = ({1'b0, ptr_q} == K);
    assign cell_ctrl[k].swap_hi = (({1'b0, ptr_q} + (IDX_W + 1)'(1)) == K);

    if (k == 0) begin : g_head
      assign prev_data = feed;
    end else begin : g_body
      assign prev_data = cell_data[k-1];
    end

    // bottom cell sees zeros beyond the chain
    if (k == STACK_DEPTH - 1) begin : g_tail
      assign next_data = '0;
      assign next_lane = '0;
    end else begin : g_link
      assign next_data = cell_data[k+1];
      assign next_lane = cell_lane[k+1];
    end

    spr_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[k]),
      .prev_data_i(prev_data),
      .next_data_i(next_data),
      .next_lane_i(next_lane),
      .data_o     (cell_data[k]),
      .lane_o     (cell_lane[k])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      steps_q     <= '0;
      ptr_q       <= '0;
      val_q       <= '0;
      status_q    <= spr_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // result leaves when taken; a finished word reloads it below
      if (out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= spr_pkg::ST_OK;
            state_q  <= S_DONE;
            case (spr_pkg::mode_e'(in_data_i.mode))
              spr_pkg::MODE_PUSH: begin
                if (c_ext >= depth_ext) begin
                  status_q <= spr_pkg::ST_FULL;
                end else begin
                  val_q   <= push_val;
                  count_q <= count_q + CNT_W'(1);
                  state_q <= S_PUSH;
                end
              end
              spr_pkg::MODE_DUP: begin
                // index check comes before the full check
                if (n_ext >= c_ext) begin
                  status_q <= spr_pkg::ST_INDEX;
                end else if (c_ext >= depth_ext) begin
                  status_q <= spr_pkg::ST_FULL;
                end else begin
                  steps_q <= CNT_W'(in_data_i.position);
                  count_q <= count_q + CNT_W'(1);
                  state_q <= S_LOAD;
                end
              end
              spr_pkg::MODE_DROP: begin
                if (n_ext > c_ext) begin
                  status_q <= spr_pkg::ST_INDEX;
                end else if (in_data_i.position != '0) begin
                  steps_q <= CNT_W'(in_data_i.position);
                  count_q <= count_q - CNT_W'(in_data_i.position);
                  state_q <= S_SHIFT_UP;
                end
              end
              spr_pkg::MODE_DIG: begin
                if (n_ext + CMP_W'(2) > c_ext) begin
                  status_q <= spr_pkg::ST_INDEX;
                end else begin
                  ptr_q   <= IDX_W'(in_data_i.position);
                  state_q <= S_SWAP_DOWN;
                end
              end
              spr_pkg::MODE_DUG: begin
                // dug with depth zero on a non-empty stack leaves it as is
                if (n_ext >= c_ext) begin
                  status_q <= spr_pkg::ST_INDEX;
                end else if (in_data_i.position != '0) begin
                  ptr_q   <= '0;
                  steps_q <= CNT_W'(in_data_i.position);
                  state_q <= S_SWAP_UP;
                end
              end
              default: ;
            endcase
          end
        end
        S_PUSH, S_PUSH_LANE: state_q <= S_DONE;
        S_LOAD: state_q <= (steps_q == '0) ? S_PUSH_LANE : S_LANE;
        S_LANE: begin
          steps_q <= steps_q - CNT_W'(1);
          if (steps_q == CNT_W'(1)) begin
            state_q <= S_PUSH_LANE;
          end
        end
        S_SHIFT_UP: begin
          steps_q <= steps_q - CNT_W'(1);
          if (steps_q == CNT_W'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_SWAP_UP: begin
          ptr_q   <= ptr_q + IDX_W'(1);
          steps_q <= steps_q - CNT_W'(1);
          if (steps_q == CNT_W'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_SWAP_DOWN: begin
          if (ptr_q == '0) begin
            state_q <= S_DONE;
          end else begin
            ptr_q <= ptr_q - IDX_W'(1);
          end
        end
        S_DONE: begin
          // wait for the result register to be free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q            <= 1'b1;
            out_data_q.top_value   <= top_now;
            out_data_q.entry_count <= spr_pkg::COUNT_W'(count_q);
            out_data_q.status      <= status_q;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hdl/spr_checker.sv
module spr_checker #(
  parameter int unsigned STACK_DEPTH = spr_pkg::STACK_DEPTH_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input spr_pkg::out_word_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_data_o.status))
    else $error("undefined status code");

  // an empty stack reports a zero top
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (STACK_DEPTH < 32) && out_valid_o && (out_data_o.entry_count == '0)
      |-> (out_data_o.top_value == '0))
    else $error("nonzero top on empty stack");

  // one word in flight: no new word right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while busy");

  // a taken word never makes the result register drop a pending word
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !in_ready_o |=> out_valid_o)
    else $error("pending result lost");

endmodule

bind stack_with_pick_roll_drop_unit spr_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_spr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
